FILE: rtl/lca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants for the toroidal life grid: item words,
// opcodes, configuration indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 6;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

    // smallest usable grid extent
    localparam int MIN_SIZE = 3;

    // rule constants
    localparam logic [3:0] CNT_BORN = 4'd3;
    localparam logic [3:0] CNT_KEEP = 4'd2;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_STEP  = 2'd2;

    typedef struct packed {
        t_opcode              opcode;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic                 write_value;
    } t_in_word;

    typedef struct packed {
        logic cell_value;
        logic bad_coordinate;
    } t_out_word;

    typedef enum logic [2:0] {
        RD_ITEM  = 3'd0,
        RD_LAST  = 3'd1,
        RD_ZERO  = 3'd2,
        RD_ONE   = 3'd3,
        RD_AHEAD = 3'd4
    } t_rd_sel;

    typedef struct packed {
        logic    cap_item;
        logic    clr_wr;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    load_top;
        logic    load_mid;
        logic    run;
        logic    rmw_wr;
        logic    res_cap;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    bad;
        logic    last_clear;
        logic    last_run;
        logic    out_free;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/lca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer for the life grid: clearing pass, cell access, generation sweep
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module lca_ctrl
    import lca_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_RMW    = 8'b0000_1000,
        S_ST0    = 8'b0001_0000,
        S_ST1    = 8'b0010_0000,
        S_RUN    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_ITEM;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.last_clear) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_status.op == OP_WRITE || i_status.op == OP_READ) && !i_status.bad) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ITEM;
                    n_state = S_RMW;
                end else if (i_status.op == OP_STEP) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state = S_ST0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RMW: begin
                if (i_status.op == OP_WRITE) begin
                    o_cmd.rmw_wr = 1'b1;
                end else begin
                    o_cmd.res_cap = 1'b1;
                end
                n_state = S_DONE;
            end
            S_ST0: begin
                o_cmd.load_top = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_ZERO;
                n_state = S_ST1;
            end
            S_ST1: begin
                o_cmd.load_mid = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_ONE;
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.run    = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_AHEAD;
                if (i_status.last_run) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lca_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lca_dp
// Datapath for the life grid: size registers, row memory, three-row window
// with one-row rule logic, cell access and the output register.
// ----------------------------------------------------------------------------
module lca_dp
    import lca_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_word             i_in_word,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status
);

    localparam int CIW = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CSW = $clog2(MAX_COLS + 1);
    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int CEW = (CSW > CFG_W) ? CSW : CFG_W;
    localparam int REW = (RSW > CFG_W) ? RSW : CFG_W;

    logic [CFG_W-1:0]    r_cols_cfg;
    logic [CFG_W-1:0]    r_rows_cfg;
    t_in_word            r_item;
    logic [RW-1:0]       r_cnt;
    logic [MAX_COLS-1:0] r_top;
    logic [MAX_COLS-1:0] r_mid;
    logic [MAX_COLS-1:0] r_first;
    logic                r_res_value;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [CEW-1:0]      w_cols_ext;
    logic [REW-1:0]      w_rows_ext;
    logic [CSW-1:0]      w_cols;
    logic [RSW-1:0]      w_rows;
    logic [CSW-1:0]      w_cols_last;
    logic [RW-1:0]       w_rows_last;
    logic [CIW-1:0]      w_wrap_idx;
    logic [CIW-1:0]      w_col_idx;
    logic [RW-1:0]       w_row_idx;
    logic [RW:0]         w_ahead;
    logic                w_bad;
    logic                w_last_run;

    logic                w_rd_en;
    logic [RW-1:0]       w_rd_addr;
    logic [MAX_COLS-1:0] w_rd_data;
    logic                w_wr_en;
    logic [RW-1:0]       w_wr_addr;
    logic [MAX_COLS-1:0] w_wr_data;

    logic [MAX_COLS-1:0] w_bot;
    logic [MAX_COLS-1:0] w_new_row;
    logic [MAX_COLS-1:0] w_rmw_row;
    logic [2:0]          w_wrap_l;
    logic [2:0]          w_wrap_r;

    // effective sizes, clamped to the legal range
    always_comb begin
        w_cols_ext = CEW'(r_cols_cfg);
        w_rows_ext = REW'(r_rows_cfg);
        if (w_cols_ext < CEW'(MIN_SIZE)) begin
            w_cols = CSW'(MIN_SIZE);
        end else if (w_cols_ext > CEW'(MAX_COLS)) begin
            w_cols = CSW'(MAX_COLS);
        end else begin
            w_cols = CSW'(w_cols_ext);
        end
        if (w_rows_ext < REW'(MIN_SIZE)) begin
            w_rows = RSW'(MIN_SIZE);
        end else if (w_rows_ext > REW'(MAX_ROWS)) begin
            w_rows = RSW'(MAX_ROWS);
        end else begin
            w_rows = RSW'(w_rows_ext);
        end
    end

    assign w_cols_last = w_cols - CSW'(1);
    assign w_rows_last = RW'(w_rows - RSW'(1));
    assign w_wrap_idx  = CIW'(w_cols_last);
    assign w_col_idx   = CIW'(r_item.col);
    assign w_row_idx   = RW'(r_item.row);
    assign w_ahead     = {1'b0, r_cnt} + (RW+1)'(2);
    assign w_last_run  = (r_cnt == w_rows_last);

    assign w_bad = (CEW'(r_item.col) >= CEW'(w_cols)) || (REW'(r_item.row) >= REW'(w_rows));

    assign o_status.op         = r_item.opcode;
    assign o_status.bad        = w_bad;
    assign o_status.last_clear = (r_cnt == RW'(MAX_ROWS - 1));
    assign o_status.last_run   = w_last_run;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // read address select
    always_comb begin
        w_rd_en   = i_cmd.rd_en;
        w_rd_addr = w_row_idx;
        unique case (i_cmd.rd_sel)
            RD_ITEM:  w_rd_addr = w_row_idx;
            RD_LAST:  w_rd_addr = w_rows_last;
            RD_ZERO:  w_rd_addr = '0;
            RD_ONE:   w_rd_addr = RW'(1);
            RD_AHEAD: begin
                w_rd_addr = RW'(w_ahead);
                w_rd_en   = i_cmd.rd_en && ((RSW+1)'(w_ahead) < (RSW+1)'(w_rows));
            end
            default:  w_rd_addr = w_row_idx;
        endcase
    end

    // single cell update of the fetched row
    always_comb begin
        w_rmw_row = w_rd_data;
        w_rmw_row[w_col_idx] = r_item.write_value;
    end

    // write port select
    always_comb begin
        w_wr_en   = i_cmd.clr_wr || i_cmd.run || i_cmd.rmw_wr;
        w_wr_addr = r_cnt;
        w_wr_data = '0;
        priority if (i_cmd.rmw_wr) begin
            w_wr_addr = w_row_idx;
            w_wr_data = w_rmw_row;
        end else if (i_cmd.run) begin
            w_wr_data = w_new_row;
        end else begin
            w_wr_data = '0;
        end
    end

    lca_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // row below, wrapping to the saved first row
    assign w_bot = w_last_run ? r_first : w_rd_data;

    assign w_wrap_l = {r_top[w_wrap_idx], r_mid[w_wrap_idx], w_bot[w_wrap_idx]};
    assign w_wrap_r = {r_top[0], r_mid[0], w_bot[0]};

    for (genvar g = 0; g < MAX_COLS; g++) begin : g_lane
        localparam int GL = (g == 0) ? MAX_COLS - 1 : g - 1;
        localparam int GR = (g == MAX_COLS - 1) ? 0 : g + 1;

        logic [2:0] w_left;
        logic [2:0] w_right;
        logic [3:0] w_count;
        logic       w_is_last;
        logic       w_in_use;
        logic       w_live;

        assign w_is_last = (CSW'(g) == w_cols_last);
        assign w_in_use  = (CSW'(g) < w_cols);
        assign w_left    = (g == 0) ? w_wrap_l : {r_top[GL], r_mid[GL], w_bot[GL]};
        assign w_right   = w_is_last ? w_wrap_r : {r_top[GR], r_mid[GR], w_bot[GR]};
        assign w_count   = 4'(w_left[2]) + 4'(w_left[1]) + 4'(w_left[0])
                         + 4'(w_right[2]) + 4'(w_right[1]) + 4'(w_right[0])
                         + 4'(r_top[g]) + 4'(w_bot[g]);
        assign w_live    = (w_count == CNT_BORN) || (r_mid[g] && w_count == CNT_KEEP);
        assign w_new_row[g] = w_in_use ? w_live : r_mid[g];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg  <= CFG_SIZE_RESET;
            r_rows_cfg  <= CFG_SIZE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_COLS) begin
                    r_cols_cfg <= i_cfg_data;
                end else begin
                    r_rows_cfg <= i_cfg_data;
                end
            end
            if (i_cmd.cap_item) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_wr || i_cmd.run) begin
                r_cnt <= r_cnt + RW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item      <= i_in_word;
            r_res_value <= 1'b0;
        end else if (i_cmd.res_cap) begin
            r_res_value <= w_rd_data[w_col_idx];
        end
        if (i_cmd.load_top) begin
            r_top <= w_rd_data;
        end else if (i_cmd.run) begin
            r_top <= r_mid;
        end
        if (i_cmd.load_mid) begin
            r_mid   <= w_rd_data;
            r_first <= w_rd_data;
        end else if (i_cmd.run) begin
            r_mid <= w_bot;
        end
        if (i_cmd.out_load) begin
            r_out_word.cell_value     <= r_res_value;
            r_out_word.bad_coordinate <= w_bad &&
                (r_item.opcode == OP_WRITE || r_item.opcode == OP_READ);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

FILE: rtl/life_cellular_automaton.sv
`default_nettype none
// ----------------------------------------------------------------------------
// life_cellular_automaton
// Toroidal B3/S23 life grid with cell write, cell read and generation step.
//
//   channel | direction | handshake              | word
//   in      | input     | i_in_valid / o_in_stall | t_in_word
//   out     | output    | o_out_valid / i_out_stall | t_out_word
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// write or read: one row memory access per word
// bad coordinate or unused opcode: no memory access
// step: one grid row per cycle over the clamped rows in use
// after reset a clearing pass zeroes all MAX_ROWS rows before the first word
// a result waiting on a stalled output holds the next item at its final cycle
// ----------------------------------------------------------------------------
module life_cellular_automaton
    import lca_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    lca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lca_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
`default_nettype wire

FILE: tb/life_cellular_automaton_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// life_cellular_automaton_tb
// Self-checking bench for the toroidal life grid. A scoreboard class keeps
// its own copy of the cell grid and of both size registers. It predicts the
// result word of every accepted input word and checks output words in order.
// A directed part covers corner wrap, the coordinate extremes, the unused
// opcode, bad coordinates and cells kept outside the in-use area. Random
// phases then run at several grid sizes, extremes included, with random
// input gaps and random output stall.
// ----------------------------------------------------------------------------
module life_cellular_automaton_tb;
    import lca_pkg::*;

    localparam t_opcode OP_UNUSED      = 2'd3;
    localparam int      WATCHDOG_LIMIT = 4000;
    localparam int      CFG_PAUSE      = 8;
    localparam int      END_PAUSE      = DEF_MAX_ROWS + 8;
    localparam int      PHASE_WORDS    = 15;
    localparam int      COORD_MAX      = (1 << COORD_W) - 1;

    class life_grid_scoreboard;
        bit [DEF_MAX_COLS-1:0] grid [DEF_MAX_ROWS];
        logic [CFG_W-1:0]      cols_reg;
        logic [CFG_W-1:0]      rows_reg;
        t_out_word             expected_words [$];
        int                    errors;

        function new();
            cols_reg = CFG_SIZE_RESET;
            rows_reg = CFG_SIZE_RESET;
            errors   = 0;
            foreach (grid[r]) grid[r] = '0;
        endfunction

        function int clamp_size(logic [CFG_W-1:0] v, int maxv);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > maxv) return maxv;
            return int'(v);
        endfunction

        function int cols();
            return clamp_size(cols_reg, DEF_MAX_COLS);
        endfunction

        function int rows();
            return clamp_size(rows_reg, DEF_MAX_ROWS);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_COLS) cols_reg = data;
            else if (idx == CFG_ROWS) rows_reg = data;
        endfunction

        function void advance_generation();
            bit [DEF_MAX_COLS-1:0] nxt [DEF_MAX_ROWS];
            int nc, nr, n, rp, rn, cp, cn;
            nc  = cols();
            nr  = rows();
            nxt = grid;
            for (int r = 0; r < nr; r++) begin
                rp = (r + nr - 1) % nr;
                rn = (r + 1) % nr;
                for (int c = 0; c < nc; c++) begin
                    cp = (c + nc - 1) % nc;
                    cn = (c + 1) % nc;
                    n = 0;
                    n += grid[rp][cp];
                    n += grid[rp][c];
                    n += grid[rp][cn];
                    n += grid[r][cp];
                    n += grid[r][cn];
                    n += grid[rn][cp];
                    n += grid[rn][c];
                    n += grid[rn][cn];
                    nxt[r][c] = (n == CNT_BORN) || (grid[r][c] && n == CNT_KEEP);
                end
            end
            grid = nxt;
        endfunction

        function void note_input(t_in_word w);
            t_out_word res;
            res = '0;
            if (w.opcode == OP_WRITE || w.opcode == OP_READ) begin
                if (w.col >= cols() || w.row >= rows()) res.bad_coordinate = 1'b1;
                else if (w.opcode == OP_WRITE) grid[w.row][w.col] = w.write_value;
                else res.cell_value = grid[w.row][w.col];
            end else if (w.opcode == OP_STEP) begin
                advance_generation();
            end
            expected_words.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("result word %b with nothing expected", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.cell_value !== want.cell_value)
                report($sformatf("cell_value got %b want %b", got.cell_value,
                                 want.cell_value));
            if (got.bad_coordinate !== want.bad_coordinate)
                report($sformatf("bad_coordinate got %b want %b", got.bad_coordinate,
                                 want.bad_coordinate));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    life_grid_scoreboard sb = new();
    bit                  gaps_on = 1'b1;

    life_cellular_automaton u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // output stall: short bursts, a few long ones, and quiet stretches
    initial begin : out_stall_gen
        int   hold;
        int   pick;
        logic lvl;
        i_out_stall = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                lvl  = 1'b0;
                hold = $urandom_range(1, 25);
            end else if (pick < 90) begin
                lvl  = 1'b1;
                hold = $urandom_range(1, 3);
            end else begin
                lvl  = 1'b1;
                hold = $urandom_range(10, 30);
            end
            repeat (hold) begin
                @(posedge i_clk);
                i_out_stall <= lvl;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic put(input t_opcode op, input int col, input int row, input bit v);
        t_in_word w;
        w.opcode      = op;
        w.col         = COORD_W'(col);
        w.row         = COORD_W'(row);
        w.write_value = v;
        send_word(w);
    endtask

    task automatic wait_idle(input int pause);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    task automatic set_size(input int cols, input int rows);
        wait_idle(CFG_PAUSE);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= CFG_W'(cols);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_COLS, CFG_W'(cols));
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= CFG_W'(rows);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_ROWS, CFG_W'(rows));
        i_cfg_valid <= 1'b0;
    endtask

    // seed the grid first, then mix writes, reads, steps and noise
    task automatic run_random(input int count);
        int      pick;
        int      cols;
        int      rows;
        int      col;
        int      row;
        bit      v;
        t_opcode op;
        for (int i = 0; i < count; i++) begin
            cols = sb.cols();
            rows = sb.rows();
            pick = $urandom_range(0, 99);
            if (i < count / 3 || pick < 40) op = OP_WRITE;
            else if (pick < 76) op = OP_READ;
            else if (pick < 94) op = OP_STEP;
            else op = OP_UNUSED;
            if ($urandom_range(0, 99) < 12) begin
                col = $urandom_range(0, COORD_MAX);
                row = $urandom_range(0, COORD_MAX);
            end else begin
                col = $urandom_range(0, cols - 1);
                row = $urandom_range(0, rows - 1);
            end
            v = ($urandom_range(0, 99) < 45);
            put(op, col, row, v);
        end
    endtask

    initial begin : stimulus
        int phase_cols [8] = '{3, 0, 127, 5, 64, 8, 6, 64};
        int phase_rows [8] = '{3, 127, 0, 4, 64, 6, 2, 7};
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COLS;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full grid after reset, blinker across the corner
        put(OP_READ, 0, 0, 1'b0);
        put(OP_READ, COORD_MAX, COORD_MAX, 1'b0);
        put(OP_WRITE, COORD_MAX, 0, 1'b1);
        put(OP_WRITE, 0, 0, 1'b1);
        put(OP_WRITE, 1, 0, 1'b1);
        put(OP_WRITE, 10, 10, 1'b1);
        put(OP_WRITE, 10, 10, 1'b0);
        put(OP_WRITE, 20, 20, 1'b1);
        put(OP_STEP, 0, 0, 1'b0);
        put(OP_READ, 0, COORD_MAX, 1'b0);
        put(OP_READ, 0, 0, 1'b0);
        put(OP_READ, 0, 1, 1'b0);
        put(OP_READ, COORD_MAX, 0, 1'b0);
        put(OP_UNUSED, COORD_MAX, COORD_MAX, 1'b1);
        put(OP_STEP, COORD_MAX, COORD_MAX, 1'b1);
        put(OP_READ, COORD_MAX, 0, 1'b0);

        // small grid: bad coordinates, edge cell, lone cell dies
        set_size(4, 5);
        put(OP_WRITE, 4, 0, 1'b1);
        put(OP_READ, 0, 5, 1'b0);
        put(OP_READ, COORD_MAX, COORD_MAX, 1'b0);
        put(OP_WRITE, 3, 4, 1'b1);
        put(OP_READ, 3, 4, 1'b0);
        put(OP_STEP, 0, 0, 1'b0);
        put(OP_READ, 3, 4, 1'b0);

        // full size again: read back a cell outside the small area
        set_size(64, 64);
        put(OP_READ, 20, 20, 1'b0);

        foreach (phase_cols[p]) begin
            set_size(phase_cols[p], phase_rows[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            run_random(PHASE_WORDS);
        end

        wait_idle(END_PAUSE);
        if (sb.errors == 0 && sb.pending() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
